// ----- sv/rcset_pkg.sv -----
// Package for the RC switch edge trigger: widths, register indexes,
// position and reason codes, and the structs passed between modules.
// No dependencies.
`default_nettype none

package rcset_pkg;

    localparam int unsigned WidthW  = 16;
    localparam int unsigned TimeW   = 32;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned PosW    = 2;
    localparam int unsigned ReasonW = 4;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_VALID_MIN  = 3'd0,
        CFG_LOW_UPPER  = 3'd1,
        CFG_HIGH_LOWER = 3'd2,
        CFG_VALID_MAX  = 3'd3,
        CFG_DEBOUNCE   = 3'd4,
        CFG_COOLDOWN   = 3'd5
    } t_cfg_idx;

    typedef enum logic [PosW-1:0] {
        POS_UNKNOWN = 2'd0,
        POS_LOW     = 2'd1,
        POS_HIGH    = 2'd2
    } t_pos;

    typedef enum logic [ReasonW-1:0] {
        REASON_RANGE        = 4'd0,
        REASON_TIME_BACK    = 4'd1,
        REASON_BAND         = 4'd2,
        REASON_STEADY_LOW   = 4'd3,
        REASON_STEADY_HIGH  = 4'd4,
        REASON_DEB_LOW      = 4'd5,
        REASON_DEB_HIGH     = 4'd6,
        REASON_ARMED        = 4'd7,
        REASON_HIGH_UNARMED = 4'd8,
        REASON_COOLDOWN     = 4'd9,
        REASON_EDGE         = 4'd10
    } t_reason;

    typedef struct packed {
        logic [WidthW-1:0] valid_min_width;
        logic [WidthW-1:0] low_upper_width;
        logic [WidthW-1:0] high_lower_width;
        logic [WidthW-1:0] valid_max_width;
        logic [WidthW-1:0] debounce_time;
        logic [WidthW-1:0] cooldown_time;
    } t_cfg;

    typedef struct packed {
        logic               accepted;
        logic               trigger;
        logic               armed;
        logic [PosW-1:0]    stable_pos;
        logic [ReasonW-1:0] reason_code;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/rcset_if.sv -----
// Handshake channel interfaces: sample input, result output and register write.
// Depends on rcset_pkg for the field widths.
`default_nettype none

interface rcset_in_if
    import rcset_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WidthW-1:0] pwm_value;
    logic [TimeW-1:0]  sample_time;

    modport source (output valid, output pwm_value, output sample_time, input ready);
    modport sink   (input valid, input pwm_value, input sample_time, output ready);
endinterface

interface rcset_out_if
    import rcset_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               accepted;
    logic               trigger;
    logic               armed;
    logic [PosW-1:0]    stable_pos;
    logic [ReasonW-1:0] reason_code;

    modport source (output valid, output accepted, output trigger, output armed,
                    output stable_pos, output reason_code, input ready);
    modport sink   (input valid, input accepted, input trigger, input armed,
                    input stable_pos, input reason_code, output ready);
endinterface

interface rcset_cfg_if
    import rcset_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CfgIdxW-1:0] index;
    logic [WidthW-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/rcset_cfg.sv -----
// Configuration register file for the six threshold and timing registers.
// Depends on rcset_pkg and rcset_cfg_if.
`default_nettype none

module rcset_cfg
    import rcset_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rcset_cfg_if.sink   i_cfg,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.valid_min_width  <= 16'd900;
            r_cfg.low_upper_width  <= 16'd1300;
            r_cfg.high_lower_width <= 16'd1700;
            r_cfg.valid_max_width  <= 16'd2100;
            r_cfg.debounce_time    <= 16'd50;
            r_cfg.cooldown_time    <= 16'd1000;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_VALID_MIN:  r_cfg.valid_min_width  <= i_cfg.data;
                CFG_LOW_UPPER:  r_cfg.low_upper_width  <= i_cfg.data;
                CFG_HIGH_LOWER: r_cfg.high_lower_width <= i_cfg.data;
                CFG_VALID_MAX:  r_cfg.valid_max_width  <= i_cfg.data;
                CFG_DEBOUNCE:   r_cfg.debounce_time    <= i_cfg.data;
                CFG_COOLDOWN:   r_cfg.cooldown_time    <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- sv/rcset_core.sv -----
// Switch state and the single-pass decision logic for one sample.
// Depends on rcset_pkg.
`default_nettype none

module rcset_core
    import rcset_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [WidthW-1:0] i_pwm_value,
    input  wire logic [TimeW-1:0]  i_sample_time,
    input  wire t_cfg              i_cfg,
    output t_result                o_result
);

    logic             r_have_last_time, n_have_last_time;
    logic [TimeW-1:0] r_last_time,      n_last_time;
    t_pos             r_pending_pos,    n_pending_pos;
    logic             r_have_pending,   n_have_pending;
    logic [TimeW-1:0] r_pending_since,  n_pending_since;
    t_pos             r_settled_pos,    n_settled_pos;
    logic             r_armed_flag,     n_armed_flag;
    logic             r_have_fired,     n_have_fired;
    logic [TimeW-1:0] r_fired_time,     n_fired_time;

    t_pos             pos;
    logic             range_bad;
    logic             time_bad;
    logic             new_pending;
    logic [TimeW-1:0] since_eff;
    logic [TimeW-1:0] pend_elapsed;
    logic [TimeW-1:0] fire_elapsed;
    logic             debounced;
    logic             cooldown_block;
    t_reason          reason;
    logic             accepted;
    logic             trigger;

    always_comb begin
        range_bad = (i_pwm_value < i_cfg.valid_min_width) ||
                    (i_pwm_value > i_cfg.valid_max_width);
        time_bad  = r_have_last_time && (i_sample_time < r_last_time);

        if (i_pwm_value <= i_cfg.low_upper_width) begin
            pos = POS_LOW;
        end else if (i_pwm_value >= i_cfg.high_lower_width) begin
            pos = POS_HIGH;
        end else begin
            pos = POS_UNKNOWN;
        end

        new_pending    = !r_have_pending || (r_pending_pos != pos);
        since_eff      = new_pending ? i_sample_time : r_pending_since;
        pend_elapsed   = i_sample_time - since_eff;
        fire_elapsed   = i_sample_time - r_fired_time;
        debounced      = pend_elapsed >= {{(TimeW-WidthW){1'b0}}, i_cfg.debounce_time};
        cooldown_block = r_have_fired &&
                         (fire_elapsed < {{(TimeW-WidthW){1'b0}}, i_cfg.cooldown_time});
    end

    always_comb begin
        n_have_last_time = r_have_last_time;
        n_last_time      = r_last_time;
        n_pending_pos    = r_pending_pos;
        n_have_pending   = r_have_pending;
        n_pending_since  = r_pending_since;
        n_settled_pos    = r_settled_pos;
        n_armed_flag     = r_armed_flag;
        n_have_fired     = r_have_fired;
        n_fired_time     = r_fired_time;
        accepted         = 1'b0;
        trigger          = 1'b0;
        reason           = REASON_RANGE;

        if (range_bad) begin
            reason = REASON_RANGE;
        end else if (time_bad) begin
            reason = REASON_TIME_BACK;
        end else begin
            accepted         = 1'b1;
            n_have_last_time = 1'b1;
            n_last_time      = i_sample_time;
            if (pos == POS_UNKNOWN) begin
                n_pending_pos   = POS_UNKNOWN;
                n_have_pending  = 1'b0;
                n_pending_since = '0;
                reason          = REASON_BAND;
            end else if (pos == r_settled_pos) begin
                n_pending_pos   = POS_UNKNOWN;
                n_have_pending  = 1'b0;
                n_pending_since = '0;
                reason          = (pos == POS_LOW) ? REASON_STEADY_LOW : REASON_STEADY_HIGH;
            end else if (!debounced) begin
                n_pending_pos   = pos;
                n_have_pending  = 1'b1;
                n_pending_since = since_eff;
                reason          = (pos == POS_LOW) ? REASON_DEB_LOW : REASON_DEB_HIGH;
            end else begin
                n_settled_pos   = pos;
                n_pending_pos   = POS_UNKNOWN;
                n_have_pending  = 1'b0;
                n_pending_since = '0;
                if (pos == POS_LOW) begin
                    n_armed_flag = 1'b1;
                    reason       = REASON_ARMED;
                end else if (!r_armed_flag) begin
                    reason = REASON_HIGH_UNARMED;
                end else begin
                    n_armed_flag = 1'b0;
                    if (cooldown_block) begin
                        reason = REASON_COOLDOWN;
                    end else begin
                        n_have_fired = 1'b1;
                        n_fired_time = i_sample_time;
                        trigger      = 1'b1;
                        reason       = REASON_EDGE;
                    end
                end
            end
        end

        o_result.accepted    = accepted;
        o_result.trigger     = trigger;
        o_result.armed       = n_armed_flag;
        o_result.stable_pos  = n_settled_pos;
        o_result.reason_code = reason;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_last_time <= 1'b0;
            r_last_time      <= '0;
            r_pending_pos    <= POS_UNKNOWN;
            r_have_pending   <= 1'b0;
            r_pending_since  <= '0;
            r_settled_pos    <= POS_UNKNOWN;
            r_armed_flag     <= 1'b0;
            r_have_fired     <= 1'b0;
            r_fired_time     <= '0;
        end else if (i_step) begin
            r_have_last_time <= n_have_last_time;
            r_last_time      <= n_last_time;
            r_pending_pos    <= n_pending_pos;
            r_have_pending   <= n_have_pending;
            r_pending_since  <= n_pending_since;
            r_settled_pos    <= n_settled_pos;
            r_armed_flag     <= n_armed_flag;
            r_have_fired     <= n_have_fired;
            r_fired_time     <= n_fired_time;
        end
    end

    a_reject_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !o_result.accepted) |=>
            $stable(r_last_time) && $stable(r_settled_pos) && $stable(r_armed_flag))
        else $error("rejected sample changed the switch state");

    a_trigger_records_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.trigger) |=>
            r_have_fired && !r_armed_flag && (r_fired_time == $past(i_sample_time)))
        else $error("trigger did not record its fire time or clear the armed flag");

    a_trigger_needs_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.trigger) |-> (r_armed_flag && o_result.stable_pos == POS_HIGH))
        else $error("trigger fired without a prior armed low");

    a_pending_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have_pending |-> (r_pending_pos == POS_UNKNOWN))
        else $error("pending position set with no pending flag");

endmodule

`default_nettype wire

// ----- sv/rc_switch_edge_trigger.sv -----
// RC switch edge trigger top level: input register, decision core, result register.
// An input transfer fills the input register; the core result moves to the result
// register once it is empty or taken, which also frees the input side. Throughput
// is one sample per cycle while results are taken. Synchronous active-low reset
// restores the register defaults, clears the switch state and empties both registers.
`default_nettype none

module rc_switch_edge_trigger
    import rcset_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rcset_in_if.sink    i_in,
    rcset_out_if.source o_out,
    rcset_cfg_if.sink   i_cfg
);

    logic              r_in_valid;
    logic [WidthW-1:0] r_in_pwm_value;
    logic [TimeW-1:0]  r_in_sample_time;
    logic              r_out_valid;
    t_result           r_out;

    t_cfg              cfg;
    t_result           result;
    logic              advance;
    logic              in_xfer;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_xfer    = i_in.valid && i_in.ready;

    rcset_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    rcset_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_pwm_value   (r_in_pwm_value),
        .i_sample_time (r_in_sample_time),
        .i_cfg         (cfg),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_pwm_value   <= i_in.pwm_value;
            r_in_sample_time <= i_in.sample_time;
        end
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.accepted    = r_out.accepted;
    assign o_out.trigger     = r_out.trigger;
    assign o_out.armed       = r_out.armed;
    assign o_out.stable_pos  = r_out.stable_pos;
    assign o_out.reason_code = r_out.reason_code;

endmodule

`default_nettype wire
